@@ rtl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types, field widths, register indexes and defaults for the bilinear
// image scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

    localparam int PIXEL_W      = 32;
    localparam int CHAN_W       = 8;
    localparam int SRC_COORD_W  = 8;
    localparam int DST_COORD_W  = 12;
    localparam int STEP_W       = 24;
    localparam int DIM_W        = 9;
    localparam int POS_W        = DST_COORD_W + STEP_W;
    localparam int POS_FRAC_W   = 16;
    localparam int DIM_CMP_W    = 13;
    localparam int S_TDATA_W    = 72;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 24;

    localparam int DEF_MAX_SRC_WIDTH  = 256;
    localparam int DEF_MAX_SRC_HEIGHT = 256;
    localparam int DEF_FRAC_BITS      = 8;

    localparam logic [DIM_W-1:0]  RST_SRC_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]  RST_SRC_HEIGHT = 9'd256;
    localparam logic [STEP_W-1:0] RST_X_STEP     = 24'd65536;
    localparam logic [STEP_W-1:0] RST_Y_STEP     = 24'd65536;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_X_STEP     = 2'd2,
        REG_Y_STEP     = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    // parity of each neighbour coordinate, picks the bank it came from
    typedef struct packed {
        logic x0;
        logic x1;
        logic y0;
        logic y1;
    } t_nbr_sel;

endpackage

`default_nettype wire

@@ rtl/bis_ram.sv @@
// ----------------------------------------------------------------------------
// bis_ram
// Generic single-port synchronous RAM, registered read, one access a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/bis_axis.sv @@
// ----------------------------------------------------------------------------
// bis_axis
// Maps one fixed-point source position onto the two neighbour coordinates
// (saturated to the last row/column) and the blend weight.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_axis #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 8,
    parameter int CW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  wire logic [bis_pkg::POS_W-1:0] i_pos,
    input  wire logic [bis_pkg::DIM_W-1:0] i_dim,
    output logic      [CW-1:0]             o_c0,
    output logic      [CW-1:0]             o_c1,
    output logic      [FRAC_BITS-1:0]      o_w
);
    import bis_pkg::*;

    localparam int IP_W = POS_W - POS_FRAC_W;

    logic [DIM_CMP_W-1:0] dim_sat;
    logic [DIM_CMP_W-1:0] last;
    logic [IP_W-1:0]      ip;

    always_comb begin
        if (i_dim == '0) begin
            dim_sat = DIM_CMP_W'(1);
        end else if (DIM_CMP_W'(i_dim) > DIM_CMP_W'(MAX_DIM)) begin
            dim_sat = DIM_CMP_W'(MAX_DIM);
        end else begin
            dim_sat = DIM_CMP_W'(i_dim);
        end
    end

    assign last = dim_sat - DIM_CMP_W'(1);
    assign ip   = i_pos[POS_W-1:POS_FRAC_W];

    always_comb begin
        if (ip > IP_W'(last)) begin
            o_c0 = CW'(last);
        end else begin
            o_c0 = CW'(ip);
        end
    end

    assign o_c1 = (DIM_CMP_W'(o_c0) == last) ? o_c0 : o_c0 + CW'(1);
    assign o_w  = i_pos[POS_FRAC_W-1 -: FRAC_BITS];

endmodule

`default_nettype wire

@@ rtl/bis_blend.sv @@
// ----------------------------------------------------------------------------
// bis_blend
// Per-channel linear blend of two ARGB pixels, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_blend #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic [bis_pkg::PIXEL_W-1:0] i_p,
    input  wire logic [bis_pkg::PIXEL_W-1:0] i_q,
    input  wire logic [FRAC_BITS-1:0]        i_f,
    output logic      [bis_pkg::PIXEL_W-1:0] o_v
);
    import bis_pkg::*;

    localparam int WW = FRAC_BITS + 1;
    localparam int SW = CHAN_W + WW + 1;
    localparam int NCH = PIXEL_W / CHAN_W;

    logic [WW-1:0] w_inv;

    assign w_inv = (WW'(1) << FRAC_BITS) - WW'(i_f);

    always_comb begin
        logic [SW-1:0] acc;
        logic [SW-1:0] shf;
        o_v = '0;
        for (int c = 0; c < NCH; c++) begin
            acc = SW'(i_p[c*CHAN_W +: CHAN_W]) * SW'(w_inv)
                + SW'(i_q[c*CHAN_W +: CHAN_W]) * SW'(i_f);
            shf = acc >> FRAC_BITS;
            o_v[c*CHAN_W +: CHAN_W] = shf[CHAN_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bilinear_image_scaler_top.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_scaler_top
// Bilinear scaler over a source frame held in four parity-banked RAMs.
//
//  channel  direction  handshake             payload
//  s        in         i_s_tvalid/o_s_tready tuser: action
//                                            tdata: src_x, src_y, pixel_in,
//                                                   dst_col, dst_row
//  m        out        o_m_tvalid/i_m_tready tdata: pixel_out
//  cfg      in         i_cfg_valid/o_cfg_ready addr: register, data: value
//
// One item per cycle while m does not stall; a sample's products are
// registered at its transfer, then come the bank read, the horizontal
// blend (registered in stage 3) and the vertical blend (output register).
// The four banks split the frame by row and column parity, so all four
// neighbours are read in the same cycle. Loads finish at the bank write.
// Reset clears the pipeline valids and the registers; the frame is not
// cleared. A stall on m freezes every stage and input transfers with it.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_scaler_top #(
    parameter int MAX_SRC_WIDTH  = bis_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = bis_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int FRAC_BITS      = bis_pkg::DEF_FRAC_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [7:0] src_x, [15:8] src_y, [47:16] pixel_in, [59:48] dst_col,
    // [71:60] dst_row
    input  wire logic [bis_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [0] action
    input  wire logic                            i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [31:0] pixel_out
    output logic      [bis_pkg::PIXEL_W-1:0]     o_m_tdata,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bis_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [bis_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bis_pkg::*;

    localparam int LW         = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
    localparam int LH         = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BA         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int NBANK      = 4;

    // configuration
    logic [DIM_W-1:0]  r_src_width;
    logic [DIM_W-1:0]  r_src_height;
    logic [STEP_W-1:0] r_x_step;
    logic [STEP_W-1:0] r_y_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
            r_x_step     <= RST_X_STEP;
            r_y_step     <= RST_Y_STEP;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[DIM_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data[DIM_W-1:0];
                REG_X_STEP:     r_x_step     <= i_cfg_data[STEP_W-1:0];
                REG_Y_STEP:     r_y_step     <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [SRC_COORD_W-1:0] s_src_x;
    logic [SRC_COORD_W-1:0] s_src_y;
    logic [PIXEL_W-1:0]     s_pixel_in;
    logic [DST_COORD_W-1:0] s_dst_col;
    logic [DST_COORD_W-1:0] s_dst_row;

    assign s_src_x    = i_s_tdata[7:0];
    assign s_src_y    = i_s_tdata[15:8];
    assign s_pixel_in = i_s_tdata[47:16];
    assign s_dst_col  = i_s_tdata[59:48];
    assign s_dst_row  = i_s_tdata[71:60];

    logic adv;
    logic r_out_valid;

    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = adv;

    // stage 1: position products
    logic                   r_s1_valid;
    logic                   r_s1_sample;
    logic [SRC_COORD_W-1:0] r_s1_x;
    logic [SRC_COORD_W-1:0] r_s1_y;
    logic [PIXEL_W-1:0]     r_s1_pixel;
    logic [POS_W-1:0]       r_s1_pos_x;
    logic [POS_W-1:0]       r_s1_pos_y;
    logic [POS_W-1:0]       n_pos_x;
    logic [POS_W-1:0]       n_pos_y;

    assign n_pos_x = POS_W'(s_dst_col) * POS_W'(r_x_step);
    assign n_pos_y = POS_W'(s_dst_row) * POS_W'(r_y_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_sample <= (t_action'(i_s_tuser) == ACT_SAMPLE);
            r_s1_x      <= s_src_x;
            r_s1_y      <= s_src_y;
            r_s1_pixel  <= s_pixel_in;
            r_s1_pos_x  <= n_pos_x;
            r_s1_pos_y  <= n_pos_y;
        end
    end

    // neighbour coordinates
    logic [LW-1:0]        x0, x1;
    logic [LH-1:0]        y0, y1;
    logic [FRAC_BITS-1:0] fx, fy;

    bis_axis #(
        .MAX_DIM   (MAX_SRC_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .i_pos (r_s1_pos_x),
        .i_dim (r_src_width),
        .o_c0  (x0),
        .o_c1  (x1),
        .o_w   (fx)
    );

    bis_axis #(
        .MAX_DIM   (MAX_SRC_HEIGHT),
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .i_pos (r_s1_pos_y),
        .i_dim (r_src_height),
        .o_c0  (y0),
        .o_c1  (y1),
        .o_w   (fy)
    );

    // bank access: bank index is {row parity, column parity}
    logic            load_ok;
    logic [LW-1:0]   ld_col;
    logic [LH-1:0]   ld_row;
    logic [1:0]      ld_bank;
    logic [BA-1:0]   ld_addr;
    logic            ram_en   [NBANK];
    logic            ram_we   [NBANK];
    logic [BA-1:0]   ram_addr [NBANK];
    logic [PIXEL_W-1:0] w_rd  [NBANK];

    assign load_ok = (DIM_CMP_W'(r_s1_x) < DIM_CMP_W'(MAX_SRC_WIDTH))
                  && (DIM_CMP_W'(r_s1_y) < DIM_CMP_W'(MAX_SRC_HEIGHT));
    assign ld_col  = LW'(r_s1_x);
    assign ld_row  = LH'(r_s1_y);
    assign ld_bank = {ld_row[0], ld_col[0]};
    assign ld_addr = BA'(ld_row >> 1) * BA'(HALF_W) + BA'(ld_col >> 1);

    always_comb begin
        logic [LW-1:0] col;
        logic [LH-1:0] row;
        for (int b = 0; b < NBANK; b++) begin
            col = (x0[0] == b[0]) ? x0 : x1;
            row = (y0[0] == b[1]) ? y0 : y1;
            if (r_s1_sample) begin
                ram_en[b]   = adv && r_s1_valid;
                ram_we[b]   = 1'b0;
                ram_addr[b] = BA'(row >> 1) * BA'(HALF_W) + BA'(col >> 1);
            end else begin
                ram_en[b]   = adv && r_s1_valid && load_ok && (ld_bank == 2'(b));
                ram_we[b]   = 1'b1;
                ram_addr[b] = ld_addr;
            end
        end
    end

    for (genvar g = 0; g < NBANK; g++) begin : g_bank
        bis_ram #(
            .WIDTH (PIXEL_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (ram_en[g]),
            .i_we    (ram_we[g]),
            .i_addr  (ram_addr[g]),
            .i_wdata (r_s1_pixel),
            .o_rdata (w_rd[g])
        );
    end

    // stage 2: bank data, horizontal blend
    logic                 r_s2_valid;
    logic [FRAC_BITS-1:0] r_s2_fx;
    logic [FRAC_BITS-1:0] r_s2_fy;
    t_nbr_sel             r_s2_sel;
    logic [PIXEL_W-1:0]   p00, p10, p01, p11, top, bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_fx     <= fx;
            r_s2_fy     <= fy;
            r_s2_sel.x0 <= x0[0];
            r_s2_sel.x1 <= x1[0];
            r_s2_sel.y0 <= y0[0];
            r_s2_sel.y1 <= y1[0];
        end
    end

    assign p00 = w_rd[{r_s2_sel.y0, r_s2_sel.x0}];
    assign p10 = w_rd[{r_s2_sel.y0, r_s2_sel.x1}];
    assign p01 = w_rd[{r_s2_sel.y1, r_s2_sel.x0}];
    assign p11 = w_rd[{r_s2_sel.y1, r_s2_sel.x1}];

    bis_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_top (
        .i_p (p00),
        .i_q (p10),
        .i_f (r_s2_fx),
        .o_v (top)
    );

    bis_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_bot (
        .i_p (p01),
        .i_q (p11),
        .i_f (r_s2_fx),
        .o_v (bot)
    );

    // stage 3: vertical blend
    logic                 r_s3_valid;
    logic [PIXEL_W-1:0]   r_s3_top;
    logic [PIXEL_W-1:0]   r_s3_bot;
    logic [FRAC_BITS-1:0] r_s3_fy;
    logic [PIXEL_W-1:0]   n_out;
    logic [PIXEL_W-1:0]   r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_top <= top;
            r_s3_bot <= bot;
            r_s3_fy  <= r_s2_fy;
        end
    end

    bis_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_vert (
        .i_p (r_s3_top),
        .i_q (r_s3_bot),
        .i_f (r_s3_fy),
        .o_v (n_out)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // checks
    a_nbr_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_sample) |->
            ((x1 == x0 || x1 == x0 + LW'(1)) && (y1 == y0 || y1 == y0 + LH'(1))))
        else $error("neighbour coordinates not adjacent");

    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_sample) |->
            $onehot0({ram_en[3], ram_en[2], ram_en[1], ram_en[0]}))
        else $error("load wrote more than one bank");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_valid && !r_s1_sample) |=> !r_s2_valid)
        else $error("load produced a result");

    a_stall_holds_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && r_s2_valid) |=> ($stable(w_rd[0]) && $stable(w_rd[3]) && r_s2_valid))
        else $error("bank data lost during stall");

endmodule

`default_nettype wire
